// File: src/named_counting_semaphore_table_top_assert.svh
// Assertion macros used by the checker of the semaphore table.
`ifndef NAMED_COUNTING_SEMAPHORE_TABLE_TOP_ASSERT_SVH
`define NAMED_COUNTING_SEMAPHORE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define NCST_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("semaphore table assertion failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define NCST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("semaphore table assertion failed");

`endif

// File: src/ncst_pkg.sv
// Package with codes, widths and shared types of the semaphore table.
package ncst_pkg;

	localparam int FUNC_W   = 3;
	localparam int NAME_W   = 64;
	localparam int COUNT_W  = 16;
	localparam int REFS_W   = 8;
	localparam int PID_W    = 8;
	localparam int STATUS_W = 3;
	localparam int SLOTNO_W = 4;
	localparam int INDEX_W  = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [REFS_W-1:0]  REFS_MAX  = '1;

	localparam logic [FUNC_W-1:0] FN_OPEN  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_CLOSE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_WAIT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POST  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_RETRY = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_BLOCKED  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_QFULL    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NOSLOT   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_BADINDEX = 3'd5;
	localparam logic [STATUS_W-1:0] STAT_NOTYET   = 3'd6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_EXEC,
		S_RESP
	} state_t;

	typedef struct packed {
		logic done;
		logic hit;
		logic free_ok;
	} scan_stat_t;

endpackage

// File: src/ncst_scan.sv
// Name store and sequential name lookup with first-free-slot search.
module ncst_scan import ncst_pkg::*; #(
	parameter int NUM_SLOTS  = 16,
	parameter int NAME_BYTES = 8,
	localparam int KEY_W  = 8 * NAME_BYTES,
	localparam int SLOT_W = $clog2(NUM_SLOTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KEY_W-1:0]  key,
	input  logic [NUM_SLOTS-1:0] slot_free,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_idx,
	input  logic [KEY_W-1:0]  wr_name,
	output scan_stat_t        stat,
	output logic [SLOT_W-1:0] sel_idx
);

	localparam int SCAN_W = $clog2(NUM_SLOTS + 1);

	logic [KEY_W-1:0]  name_mem [NUM_SLOTS];
	logic              busy_q;
	logic [SCAN_W-1:0] scan_q;
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] rd_idx_s1;
	logic [KEY_W-1:0]  name_s1;
	logic              free_ok_q;
	logic [SLOT_W-1:0] free_idx_q;
	logic              issue;
	logic              hit;
	logic              last;
	logic              free_now;

	assign issue    = busy_q && (scan_q < SCAN_W'(NUM_SLOTS));
	assign hit      = rd_vld_s1 && !slot_free[rd_idx_s1] && (name_s1 == key);
	assign last     = rd_vld_s1 && (rd_idx_s1 == SLOT_W'(NUM_SLOTS - 1));
	assign free_now = rd_vld_s1 && slot_free[rd_idx_s1];

	always_comb begin
		stat.done    = hit || last;
		stat.hit     = hit;
		stat.free_ok = free_ok_q || free_now;
		if (hit || !free_ok_q) begin
			sel_idx = rd_idx_s1;
		end else begin
			sel_idx = free_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			name_mem[wr_idx] <= wr_name;
		end
		if (issue) begin
			name_s1   <= name_mem[scan_q[SLOT_W-1:0]];
			rd_idx_s1 <= scan_q[SLOT_W-1:0];
		end
		if (free_now && !free_ok_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (start) begin
			busy_q    <= 1'b1;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			free_ok_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue && !stat.done;
			if (issue) begin
				scan_q <= scan_q + SCAN_W'(1);
			end
			if (stat.done) begin
				busy_q <= 1'b0;
			end
			if (free_now) begin
				free_ok_q <= 1'b1;
			end
		end
	end

endmodule

// File: src/named_counting_semaphore_table_top.sv
// Top level of the named counting semaphore table with per-slot wait queues.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+---------------------------------------------
//   request | in_valid / in_ready    | func, name_key, init_value, sem_index, caller_pid
//   result  | out_valid / out_ready  | status, slot_number, wake_valid, wake_pid
//
// Wait, post and retry pass from one request to the next through slot record
// read, update and result. Open and close first scan the name store one slot per
// cycle; bad or unknown requests go straight to the result.
// Reset marks every slot free and clears the record-valid and control flops at once; no clearing pass.
// A stalled result holds in the output register while the next request is taken.
module named_counting_semaphore_table_top import ncst_pkg::*; #(
	parameter int NUM_SLOTS   = 16,
	parameter int QUEUE_DEPTH = 16,
	parameter int NAME_BYTES  = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic [NAME_W-1:0]   name_key,
	input  logic [COUNT_W-1:0]  init_value,
	input  logic [INDEX_W-1:0]  sem_index,
	input  logic [PID_W-1:0]    caller_pid,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [SLOTNO_W-1:0] slot_number,
	output logic                wake_valid,
	output logic [PID_W-1:0]    wake_pid
);

	localparam int KEY_W  = 8 * NAME_BYTES;
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int Q_W    = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	state_t state_q, state_d;

	logic [FUNC_W-1:0]   func_q;
	logic [KEY_W-1:0]    key_q;
	logic [COUNT_W-1:0]  init_q;
	logic [PID_W-1:0]    pid_q;
	logic [SLOT_W-1:0]   sel_q;
	logic                create_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                res_wv_q;

	logic [NUM_SLOTS-1:0] slot_free_q;
	logic [NUM_SLOTS-1:0] rec_vld_q;

	logic [COUNT_W-1:0] cnt_mem  [NUM_SLOTS];
	logic [REFS_W-1:0]  refs_mem [NUM_SLOTS];
	logic [Q_W-1:0]     head_mem [NUM_SLOTS];
	logic [Q_W-1:0]     tail_mem [NUM_SLOTS];
	logic [FILL_W-1:0]  fill_mem [NUM_SLOTS];
	logic [PID_W-1:0]   pid_mem  [NUM_SLOTS][QUEUE_DEPTH];

	logic [COUNT_W-1:0] cnt_s1;
	logic [REFS_W-1:0]  refs_s1;
	logic [Q_W-1:0]     head_s1;
	logic [Q_W-1:0]     tail_s1;
	logic [FILL_W-1:0]  fill_s1;
	logic               rec_vld_s1;
	logic [PID_W-1:0]   pid_rd_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOTNO_W-1:0] slot_number_q;
	logic                wake_valid_q;
	logic [PID_W-1:0]    wake_pid_q;

	logic accept;
	logic is_scan;
	logic is_index;
	logic idx_bad;
	logic scan_start;
	logic name_we;
	logic out_load;

	scan_stat_t        scan_stat;
	logic [SLOT_W-1:0] scan_sel;

	logic [COUNT_W-1:0]  cur_cnt, nxt_cnt;
	logic [REFS_W-1:0]   cur_refs, nxt_refs;
	logic [Q_W-1:0]      cur_head, nxt_head;
	logic [Q_W-1:0]      cur_tail, nxt_tail;
	logic [FILL_W-1:0]   cur_fill, nxt_fill;
	logic [STATUS_W-1:0] ex_status;
	logic                ex_wv;
	logic                ex_pid_we;
	logic                ex_free;

	ncst_scan #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NAME_BYTES (NAME_BYTES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.key       (key_q),
		.slot_free (slot_free_q),
		.wr_en     (name_we),
		.wr_idx    (sel_q),
		.wr_name   (key_q),
		.stat      (scan_stat),
		.sel_idx   (scan_sel)
	);

	assign accept   = in_valid && in_ready;
	assign is_scan  = (func == FN_OPEN) || (func == FN_CLOSE);
	assign is_index = (func == FN_WAIT) || (func == FN_POST) || (func == FN_RETRY);
	assign idx_bad  = int'(sem_index) >= NUM_SLOTS;
	assign out_load = (state_q == S_RESP) && (!out_valid_q || out_ready);

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot_number = slot_number_q;
	assign wake_valid  = wake_valid_q;
	assign wake_pid    = wake_pid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_scan) begin
						state_d = S_SCAN;
					end else if (is_index && !idx_bad) begin
						state_d = S_READ;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_SCAN: begin
				if (scan_stat.done) begin
					if (scan_stat.hit || ((func_q == FN_OPEN) && scan_stat.free_ok)) begin
						state_d = S_READ;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_READ: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = (state_q == S_IDLE);
		scan_start = in_valid && in_ready && is_scan;
		name_we    = (state_q == S_EXEC) && create_q;
	end

	always_comb begin
		if (create_q) begin
			cur_cnt  = init_q;
			cur_refs = '0;
			cur_head = '0;
			cur_tail = '0;
			cur_fill = '0;
		end else if (rec_vld_s1) begin
			cur_cnt  = cnt_s1;
			cur_refs = refs_s1;
			cur_head = head_s1;
			cur_tail = tail_s1;
			cur_fill = fill_s1;
		end else begin
			cur_cnt  = '0;
			cur_refs = '0;
			cur_head = '0;
			cur_tail = '0;
			cur_fill = '0;
		end
		nxt_cnt   = cur_cnt;
		nxt_refs  = cur_refs;
		nxt_head  = cur_head;
		nxt_tail  = cur_tail;
		nxt_fill  = cur_fill;
		ex_status = STAT_OK;
		ex_wv     = 1'b0;
		ex_pid_we = 1'b0;
		ex_free   = 1'b0;
		case (func_q)
			FN_OPEN: begin
				if (cur_refs != REFS_MAX) begin
					nxt_refs = cur_refs + REFS_W'(1);
				end
			end
			FN_CLOSE: begin
				if (cur_refs != '0) begin
					nxt_refs = cur_refs - REFS_W'(1);
				end
				ex_free = (nxt_refs == '0);
			end
			FN_WAIT: begin
				if (cur_cnt != '0) begin
					nxt_cnt = cur_cnt - COUNT_W'(1);
				end else if (cur_fill >= FILL_W'(QUEUE_DEPTH)) begin
					ex_status = STAT_QFULL;
				end else begin
					ex_pid_we = 1'b1;
					nxt_tail  = (cur_tail == Q_W'(QUEUE_DEPTH - 1)) ? '0 : cur_tail + Q_W'(1);
					nxt_fill  = cur_fill + FILL_W'(1);
					ex_status = STAT_BLOCKED;
				end
			end
			FN_POST: begin
				if (cur_cnt != COUNT_MAX) begin
					nxt_cnt = cur_cnt + COUNT_W'(1);
				end
				if (cur_fill != '0) begin
					ex_wv    = 1'b1;
					nxt_head = (cur_head == Q_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + Q_W'(1);
					nxt_fill = cur_fill - FILL_W'(1);
				end
			end
			FN_RETRY: begin
				if (cur_cnt != '0) begin
					nxt_cnt = cur_cnt - COUNT_W'(1);
				end else begin
					ex_status = STAT_NOTYET;
				end
			end
			default: begin
				ex_status = STAT_BADINDEX;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func;
			key_q    <= name_key[KEY_W-1:0];
			init_q   <= init_value;
			pid_q    <= caller_pid;
			sel_q    <= SLOT_W'(sem_index);
			create_q <= 1'b0;
			res_wv_q <= 1'b0;
			if (!is_scan) begin
				res_status_q <= STAT_BADINDEX;
			end
		end
		if ((state_q == S_SCAN) && scan_stat.done) begin
			sel_q    <= scan_sel;
			create_q <= (func_q == FN_OPEN) && !scan_stat.hit;
			res_status_q <= (func_q == FN_OPEN) ? STAT_NOSLOT : STAT_NOTFOUND;
		end
		if (state_q == S_READ) begin
			cnt_s1     <= cnt_mem[sel_q];
			refs_s1    <= refs_mem[sel_q];
			head_s1    <= head_mem[sel_q];
			tail_s1    <= tail_mem[sel_q];
			fill_s1    <= fill_mem[sel_q];
			rec_vld_s1 <= rec_vld_q[sel_q];
		end
		if (state_q == S_EXEC) begin
			cnt_mem[sel_q]  <= nxt_cnt;
			refs_mem[sel_q] <= nxt_refs;
			head_mem[sel_q] <= nxt_head;
			tail_mem[sel_q] <= nxt_tail;
			fill_mem[sel_q] <= nxt_fill;
			pid_rd_q        <= pid_mem[sel_q][cur_head];
			res_status_q    <= ex_status;
			res_wv_q        <= ex_wv;
			if (ex_pid_we) begin
				pid_mem[sel_q][cur_tail] <= pid_q;
			end
		end
		if (out_load) begin
			status_q      <= res_status_q;
			slot_number_q <= ((func_q == FN_OPEN) && (res_status_q == STAT_OK)) ?
				SLOTNO_W'(sel_q) : '0;
			wake_valid_q  <= res_wv_q;
			wake_pid_q    <= res_wv_q ? pid_rd_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_free_q <= '1;
			rec_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EXEC) begin
				rec_vld_q[sel_q] <= 1'b1;
				if (func_q == FN_OPEN) begin
					slot_free_q[sel_q] <= 1'b0;
				end else if ((func_q == FN_CLOSE) && ex_free) begin
					slot_free_q[sel_q] <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/ncst_checker.sv
// Port-level checker for the semaphore table and its bind to the top level.
`include "named_counting_semaphore_table_top_assert.svh"

module ncst_checker import ncst_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [SLOTNO_W-1:0] slot_number,
	input logic                wake_valid,
	input logic [PID_W-1:0]    wake_pid
);

	// The table serves one request at a time, so it is busy right after taking one.
	`NCST_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
	`NCST_ASSERT_NOW(a_wake_only_ok, out_valid && wake_valid, status == STAT_OK)
	`NCST_ASSERT_NOW(a_pid_zero_no_wake, out_valid && !wake_valid && out_ready, wake_pid == '0)
	`NCST_ASSERT_NOW(a_slot_zero_on_err, out_valid && (status != STAT_OK), slot_number == '0)

endmodule

bind named_counting_semaphore_table_top ncst_checker u_ncst_checker (.*);
